// ===== rtl/core/ctl_pkg.sv =====
// shared types and constants for the connection timeout list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctl_pkg;

    localparam int ConnIdW  = 6;
    localparam int SlotsW   = 16;
    localparam int SlotSecW = 12;
    localparam int TimeW    = 32;
    localparam int ProdW    = SlotsW + SlotSecW;

    localparam logic [SlotSecW-1:0] SlotSecReset = 12'd5;

    // most expired ids removed by one scan
    localparam int MaxResults = 64;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_SCAN    = 2'd2;

    // write enables of the link store arrays
    typedef struct packed {
        logic vld;
        logic exp;
        logic prv;
        logic nxt;
    } ctl_wen_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctl_expiry_unit.sv =====
// expiry time unit: registered slots times slot length, then saturating add of now
// depends on ctl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctl_expiry_unit (
    input  wire logic                         clk,
    input  wire logic [ctl_pkg::SlotsW-1:0]   slots,
    input  wire logic [ctl_pkg::SlotSecW-1:0] slot_seconds,
    input  wire logic [ctl_pkg::TimeW-1:0]    now,
    output logic      [ctl_pkg::TimeW-1:0]    expiry
);
    import ctl_pkg::*;

    logic [ProdW-1:0] product_reg;
    logic [TimeW:0]   sum;

    always_ff @(posedge clk)
    begin
        product_reg <= slots * slot_seconds;
    end

    assign sum    = {1'b0, now} + (TimeW + 1)'(product_reg);
    assign expiry = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/ctl_link_store.sv =====
// per-id node store: valid flag, expiry time, prev and next links
// one read address shared by all arrays with registered read data, one write port per array; depends on ctl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctl_link_store #(
    parameter  int ID_COUNT = 64,
    localparam int IdW      = $clog2(ID_COUNT)
) (
    input  wire logic                      clk,
    input  wire logic [IdW-1:0]            rd_addr,
    output logic                           rd_valid,
    output logic [ctl_pkg::TimeW-1:0]      rd_expire,
    output logic [IdW-1:0]                 rd_prev,
    output logic [IdW-1:0]                 rd_next,
    input  wire ctl_pkg::ctl_wen_t         wen,
    input  wire logic [IdW-1:0]            vld_addr,
    input  wire logic                      vld_data,
    input  wire logic [IdW-1:0]            exp_addr,
    input  wire logic [ctl_pkg::TimeW-1:0] exp_data,
    input  wire logic [IdW-1:0]            prv_addr,
    input  wire logic [IdW-1:0]            prv_data,
    input  wire logic [IdW-1:0]            nxt_addr,
    input  wire logic [IdW-1:0]            nxt_data
);
    import ctl_pkg::*;

    logic             vld_mem [ID_COUNT];
    logic [TimeW-1:0] exp_mem [ID_COUNT];
    logic [IdW-1:0]   prv_mem [ID_COUNT];
    logic [IdW-1:0]   nxt_mem [ID_COUNT];

    always_ff @(posedge clk)
    begin
        if (wen.vld)
        begin
            vld_mem[vld_addr] <= vld_data;
        end
        rd_valid <= vld_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.exp)
        begin
            exp_mem[exp_addr] <= exp_data;
        end
        rd_expire <= exp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.prv)
        begin
            prv_mem[prv_addr] <= prv_data;
        end
        rd_prev <= prv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.nxt)
        begin
            nxt_mem[nxt_addr] <= nxt_data;
        end
        rd_next <= nxt_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/connection_timeout_list.sv =====
// connection timeout list: one timer per id in a doubly linked list ordered by arming
// add or refresh: S_LOOK reads the id and unlinks it if armed, S_APPEND puts it at the tail, S_RESP loads
// the output register; op 3 and an out-of-range id go straight to S_RESP, an unarmed refresh from S_LOOK.
// scan: expired ids leave from the head, at most MaxResults, each output one step later; a stalled output
// holds it. no item is accepted outside S_IDLE. reset: list empties, slot length 5; then a clearing pass
// over all ID_COUNT valid flags runs with s_tready low. depends on ctl_pkg, ctl_expiry_unit, ctl_link_store
`timescale 1ns / 1ps
`default_nettype none

module connection_timeout_list #(
    parameter int ID_COUNT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,     // op[1:0], conn_id[7:2], slots[23:8], now[55:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // accepted[0], expired_id[6:1], id_valid[7]
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [11:0] cfg_wr_data
);
    import ctl_pkg::*;

    localparam int IdW  = $clog2(ID_COUNT);
    localparam int CntW = $clog2(ID_COUNT + 1);
    localparam int RmW  = $clog2(MaxResults + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;

    logic [1:0]          in_op;
    logic [ConnIdW-1:0]  in_id;
    logic [SlotsW-1:0]   in_slots;
    logic [TimeW-1:0]    in_now;

    logic [2:0]          state_reg, state_next;
    logic [IdW-1:0]      clr_reg, clr_next;
    logic [SlotSecW-1:0] slot_sec_reg;
    logic [1:0]          op_reg, op_next;
    logic [IdW-1:0]      id_reg, id_next;
    logic [SlotsW-1:0]   slots_reg, slots_next;
    logic [TimeW-1:0]    now_reg, now_next;
    logic                acc_reg, acc_next;
    logic [IdW-1:0]      pend_reg, pend_next;
    logic                pend_v_reg, pend_v_next;
    logic [RmW-1:0]      rm_cnt_reg, rm_cnt_next;
    logic [IdW-1:0]      head_reg, head_next;
    logic [IdW-1:0]      tail_reg, tail_next;
    logic [CntW-1:0]     count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_acc_reg, out_acc_next;
    logic [ConnIdW-1:0]  out_id_reg, out_id_next;
    logic                out_idv_reg, out_idv_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;
    logic                accept;
    logic                hit;

    logic [IdW-1:0]      rd_addr;
    logic                rd_valid;
    logic [TimeW-1:0]    rd_expire;
    logic [IdW-1:0]      rd_prev;
    logic [IdW-1:0]      rd_next;
    ctl_wen_t            wen;
    logic [IdW-1:0]      vld_addr;
    logic                vld_data;
    logic [IdW-1:0]      exp_addr;
    logic [IdW-1:0]      prv_addr;
    logic [IdW-1:0]      prv_data;
    logic [IdW-1:0]      nxt_addr;
    logic [IdW-1:0]      nxt_data;
    logic [TimeW-1:0]    expiry;

    assign in_op    = s_tdata[1:0];
    assign in_id    = s_tdata[7:2];
    assign in_slots = s_tdata[23:8];
    assign in_now   = s_tdata[55:24];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_idv_reg, out_id_reg, out_acc_reg};
    assign m_tlast  = out_last_reg;

    ctl_expiry_unit u_expiry (
        .clk          (clk),
        .slots        (slots_reg),
        .slot_seconds (slot_sec_reg),
        .now          (now_reg),
        .expiry       (expiry)
    );

    ctl_link_store #(
        .ID_COUNT (ID_COUNT)
    ) u_store (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_valid  (rd_valid),
        .rd_expire (rd_expire),
        .rd_prev   (rd_prev),
        .rd_next   (rd_next),
        .wen       (wen),
        .vld_addr  (vld_addr),
        .vld_data  (vld_data),
        .exp_addr  (exp_addr),
        .exp_data  (expiry),
        .prv_addr  (prv_addr),
        .prv_data  (prv_data),
        .nxt_addr  (nxt_addr),
        .nxt_data  (nxt_data)
    );

    // head expired and still under the per-scan cap
    assign hit = (count_reg != '0) && (rm_cnt_reg != RmW'(MaxResults)) && (rd_expire < now_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        slots_next     = slots_reg;
        now_next       = now_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        pend_v_next    = pend_v_reg;
        rm_cnt_next    = rm_cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_acc_next   = out_acc_reg;
        out_id_next    = out_id_reg;
        out_idv_next   = out_idv_reg;
        out_last_next  = out_last_reg;
        wen            = '0;
        vld_addr       = id_reg;
        vld_data       = 1'b0;
        exp_addr       = id_reg;
        prv_addr       = id_reg;
        prv_data       = tail_reg;
        nxt_addr       = tail_reg;
        nxt_data       = id_reg;
        rd_addr        = head_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wen.vld  = 1'b1;
                vld_addr = clr_reg;
                clr_next = clr_reg + IdW'(1);
                if (clr_reg == IdW'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                rd_addr = (in_op == OP_SCAN) ? head_reg : IdW'(in_id);
                if (accept)
                begin
                    op_next     = in_op;
                    id_next     = IdW'(in_id);
                    slots_next  = in_slots;
                    now_next    = in_now;
                    acc_next    = 1'b0;
                    pend_v_next = 1'b0;
                    rm_cnt_next = '0;
                    case (in_op)
                        OP_ADD, OP_REFRESH:
                        begin
                            if (32'(in_id) < ID_COUNT)
                            begin
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        OP_SCAN:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (op_reg == OP_REFRESH && !rd_valid)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    // unlink an armed id before it moves to the tail
                    if (rd_valid)
                    begin
                        if (id_reg == head_reg)
                        begin
                            head_next = rd_next;
                        end
                        else
                        begin
                            wen.nxt  = 1'b1;
                            nxt_addr = rd_prev;
                            nxt_data = rd_next;
                        end
                        if (id_reg == tail_reg)
                        begin
                            tail_next = rd_prev;
                        end
                        else
                        begin
                            wen.prv  = 1'b1;
                            prv_addr = rd_next;
                            prv_data = rd_prev;
                        end
                        count_next = count_reg - CntW'(1);
                    end
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                if (count_reg == '0)
                begin
                    head_next = id_reg;
                end
                else
                begin
                    wen.nxt = 1'b1;
                    wen.prv = 1'b1;
                end
                wen.vld    = 1'b1;
                vld_data   = 1'b1;
                wen.exp    = 1'b1;
                tail_next  = id_reg;
                count_next = count_reg + CntW'(1);
                acc_next   = 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_id_next    = '0;
                    out_idv_next   = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // the removed id waits one step so its last flag is known
                if (out_free)
                begin
                    if (hit)
                    begin
                        head_next = rd_next;
                        if (head_reg == tail_reg)
                        begin
                            tail_next = rd_prev;
                        end
                        else
                        begin
                            wen.prv  = 1'b1;
                            prv_addr = rd_next;
                            prv_data = rd_prev;
                        end
                        wen.vld     = 1'b1;
                        vld_addr    = head_reg;
                        vld_data    = 1'b0;
                        count_next  = count_reg - CntW'(1);
                        rm_cnt_next = rm_cnt_reg + RmW'(1);
                        pend_next   = head_reg;
                        pend_v_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_acc_next   = 1'b0;
                            out_id_next    = ConnIdW'(pend_reg);
                            out_idv_next   = 1'b1;
                            out_last_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_acc_next   = 1'b0;
                        out_id_next    = pend_v_reg ? ConnIdW'(pend_reg) : '0;
                        out_idv_next   = pend_v_reg;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                // read ahead at whatever the head becomes
                rd_addr = head_next;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            slot_sec_reg  <= SlotSecReset;
            pend_v_reg    <= 1'b0;
            rm_cnt_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_v_reg    <= pend_v_next;
            rm_cnt_reg    <= rm_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                slot_sec_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        slots_reg    <= slots_next;
        now_reg      <= now_next;
        acc_reg      <= acc_next;
        pend_reg     <= pend_next;
        out_acc_reg  <= out_acc_next;
        out_id_reg   <= out_id_next;
        out_idv_reg  <= out_idv_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
